// ===== sv/atrsm_pkg.sv =====
// Shared types, constants and response patterns of the AT response suffix matcher.
`default_nettype none

package atrsm_pkg;

    localparam int BUFFER_DEPTH_DEF = 1024;
    localparam int BYTE_W = 8;
    localparam int IDX_W = 10;
    localparam int HIST_LEN = 24;

    localparam int OK_LEN = 6;
    localparam int ERR_LEN = 9;
    localparam int INV_LEN = 24;

    localparam logic [BYTE_W-1:0] ESC_CODE = 8'd27;
    localparam logic [BYTE_W-1:0] CHAR_END = "E";
    localparam logic [BYTE_W-1:0] CHAR_START = "u";

    localparam logic [BYTE_W-1:0] OK_PAT [OK_LEN] = '{
        8'h0D, 8'h0A, "O", "K", 8'h0D, 8'h0A
    };

    localparam logic [BYTE_W-1:0] ERR_PAT [ERR_LEN] = '{
        8'h0D, 8'h0A, "E", "R", "R", "O", "R", 8'h0D, 8'h0A
    };

    localparam logic [BYTE_W-1:0] INV_PAT [INV_LEN] = '{
        8'h0D, 8'h0A, "E", "R", "R", "O", "R", ":", " ", "I", "N", "V",
        "A", "L", "I", "D", " ", "I", "N", "P", "U", "T", 8'h0D, 8'h0A
    };

    typedef enum logic [1:0] {
        RESP_NONE    = 2'd0,
        RESP_OK      = 2'd1,
        RESP_ERROR   = 2'd2,
        RESP_INVALID = 2'd3
    } atrsm_resp_t;

    typedef struct packed {
        logic ok;
        logic err;
        logic inv;
    } atrsm_hit_t;

    typedef struct packed {
        logic [IDX_W-1:0] write_index;
        atrsm_resp_t      response_code;
        logic             frame_end;
        logic             frame_found;
        logic [IDX_W-1:0] frame_start_index;
        logic             buffer_restart;
    } atrsm_result_t;

endpackage

`default_nettype wire

// ===== sv/atrsm_rx_if.sv =====
// Input channel carrying one received serial byte per beat.
`default_nettype none

interface atrsm_rx_if;
    import atrsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/atrsm_result_if.sv =====
// Output channel carrying one match result per beat.
`default_nettype none

interface atrsm_result_if;
    import atrsm_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] write_index;
    logic [1:0]       response_code;
    logic             frame_end;
    logic             frame_found;
    logic [IDX_W-1:0] frame_start_index;
    logic             buffer_restart;

    modport source (
        output valid, output write_index, output response_code, output frame_end,
        output frame_found, output frame_start_index, output buffer_restart,
        input ready
    );
    modport sink (
        input valid, input write_index, input response_code, input frame_end,
        input frame_found, input frame_start_index, input buffer_restart,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/atrsm_cell.sv =====
// One history cell: holds a byte and its valid flag and compares its incoming byte.
`default_nettype none

module atrsm_cell #(
    parameter int POS = 0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         shift,
    input  wire logic                         flush,
    input  wire logic                         v_in,
    input  wire logic [atrsm_pkg::BYTE_W-1:0] d_in,
    output logic                              valid_q,
    output logic [atrsm_pkg::BYTE_W-1:0]      byte_q,
    output atrsm_pkg::atrsm_hit_t             hit
);
    import atrsm_pkg::*;

    localparam int OK_IDX = (POS < OK_LEN) ? OK_LEN - 1 - POS : 0;
    localparam int ERR_IDX = (POS < ERR_LEN) ? ERR_LEN - 1 - POS : 0;
    localparam int INV_IDX = (POS < INV_LEN) ? INV_LEN - 1 - POS : 0;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next = byte_reg;
        if (shift)
        begin
            valid_next = v_in & ~flush;
            byte_next = d_in;
        end
    end

    always_comb
    begin
        hit.ok = (POS >= OK_LEN) || (v_in && d_in == OK_PAT[OK_IDX]);
        hit.err = (POS >= ERR_LEN) || (v_in && d_in == ERR_PAT[ERR_IDX]);
        hit.inv = (POS >= INV_LEN) || (v_in && d_in == INV_PAT[INV_IDX]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            byte_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            byte_reg <= byte_next;
        end
    end

    assign valid_q = valid_reg;
    assign byte_q = byte_reg;
endmodule

`default_nettype wire

// ===== sv/atrsm_out_buf.sv =====
// Two-entry result buffer that decouples the matcher from the result channel.
`default_nettype none

module atrsm_out_buf (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push_valid,
    output logic                          push_ready,
    input  wire atrsm_pkg::atrsm_result_t push_data,
    atrsm_result_if.source                result
);
    import atrsm_pkg::*;

    logic          out_vld_reg;
    logic          out_vld_next;
    logic          skid_vld_reg;
    logic          skid_vld_next;
    atrsm_result_t out_data_reg;
    atrsm_result_t out_data_next;
    atrsm_result_t skid_data_reg;
    atrsm_result_t skid_data_next;
    logic          pop;
    logic          push;

    assign push_ready = ~skid_vld_reg;
    assign pop = out_vld_reg & result.ready;
    assign push = push_valid & ~skid_vld_reg;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_data_next = out_data_reg;
        skid_data_next = skid_data_reg;
        if (skid_vld_reg)
        begin
            if (pop)
            begin
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_vld_reg || pop)
            begin
                out_data_next = push_data;
                out_vld_next = 1'b1;
            end
            else
            begin
                skid_data_next = push_data;
                skid_vld_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign result.valid = out_vld_reg;
    assign result.write_index = out_data_reg.write_index;
    assign result.response_code = out_data_reg.response_code;
    assign result.frame_end = out_data_reg.frame_end;
    assign result.frame_found = out_data_reg.frame_found;
    assign result.frame_start_index = out_data_reg.frame_start_index;
    assign result.buffer_restart = out_data_reg.buffer_restart;
endmodule

`default_nettype wire

// ===== sv/at_response_suffix_matcher_top.sv =====
// Top level of the AT response suffix matcher.
`default_nettype none

// The matcher takes one received byte per beat and returns exactly one result beat for it,
// registered into the output buffer. The newest 24 bytes sit in a row of history cells that
// shift by one on every accepted byte; each cell compares its incoming byte against the three
// response patterns, so all suffix tests finish in the cycle the byte arrives. A new byte can
// be taken every cycle. Results pass through a two-entry output buffer, so the input keeps
// flowing while one result waits on the output; the input stalls only when both entries are
// full. The receive buffer itself is not stored here: only its fill count and the position
// of the latest start marker are kept.

module at_response_suffix_matcher_top #(
    parameter int BUFFER_DEPTH = atrsm_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic       cfg_write_data,
    atrsm_rx_if.sink        rx_stream,
    atrsm_result_if.source  result
);
    import atrsm_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_DEPTH - 1);

    logic              udp_enable_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [CNT_W-1:0]  sm_index_reg;
    logic [CNT_W-1:0]  sm_index_next;
    logic              sm_valid_reg;
    logic              sm_valid_next;

    logic              accept;
    logic              buf_ready;
    logic              ovf;
    logic [CNT_W-1:0]  widx;
    logic              prev_esc;
    logic              mark_hit;
    logic              mark_valid;
    logic [CNT_W-1:0]  mark_index;
    logic              fend;
    logic              restart;
    logic              ok_all;
    logic              err_all;
    logic              inv_all;
    atrsm_resp_t       code;
    atrsm_result_t     res;

    logic              cell_vin   [HIST_LEN];
    logic [BYTE_W-1:0] cell_din   [HIST_LEN];
    logic              cell_valid [HIST_LEN];
    logic [BYTE_W-1:0] cell_byte  [HIST_LEN];
    atrsm_hit_t        cell_hit   [HIST_LEN];
    logic [HIST_LEN-1:0] ok_vec;
    logic [HIST_LEN-1:0] err_vec;
    logic [HIST_LEN-1:0] inv_vec;

    assign accept = rx_stream.valid & buf_ready;
    assign rx_stream.ready = buf_ready;

    assign ovf = fill_count_reg >= CNT_LAST;
    assign widx = ovf ? '0 : fill_count_reg;

    assign cell_vin[0] = 1'b1;
    assign cell_din[0] = rx_stream.rx_byte;

    for (genvar k = 0; k < HIST_LEN; k++)
    begin : g_cell
        if (k > 0)
        begin : g_link
            assign cell_vin[k] = cell_valid[k-1] & ~ovf;
            assign cell_din[k] = cell_byte[k-1];
        end

        atrsm_cell #(
            .POS(k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (accept),
            .flush   (restart),
            .v_in    (cell_vin[k]),
            .d_in    (cell_din[k]),
            .valid_q (cell_valid[k]),
            .byte_q  (cell_byte[k]),
            .hit     (cell_hit[k])
        );

        assign ok_vec[k] = cell_hit[k].ok;
        assign err_vec[k] = cell_hit[k].err;
        assign inv_vec[k] = cell_hit[k].inv;
    end

    assign ok_all = &ok_vec;
    assign err_all = &err_vec;
    assign inv_all = &inv_vec;

    assign prev_esc = cell_valid[0] & ~ovf & (cell_byte[0] == ESC_CODE);
    assign mark_hit = prev_esc & (rx_stream.rx_byte == CHAR_START);
    assign mark_valid = mark_hit | (sm_valid_reg & ~ovf);
    assign mark_index = mark_hit ? widx - CNT_W'(1) : sm_index_reg;
    assign fend = prev_esc & (rx_stream.rx_byte == CHAR_END) & udp_enable_reg;

    always_comb
    begin
        if (fend)
        begin
            code = RESP_NONE;
        end
        else if (ok_all)
        begin
            code = RESP_OK;
        end
        else if (err_all)
        begin
            code = RESP_ERROR;
        end
        else if (inv_all)
        begin
            code = RESP_INVALID;
        end
        else
        begin
            code = RESP_NONE;
        end
    end

    assign restart = fend | (code != RESP_NONE);

    always_comb
    begin
        res.write_index = IDX_W'(widx);
        res.response_code = code;
        res.frame_end = fend;
        res.frame_found = fend & mark_valid;
        res.frame_start_index = (fend & mark_valid) ? IDX_W'(mark_index) : '0;
        res.buffer_restart = restart;
    end

    assign fill_count_next = restart ? '0 : widx + CNT_W'(1);
    assign sm_valid_next = mark_valid & ~restart;
    assign sm_index_next = mark_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            udp_enable_reg <= 1'b0;
            fill_count_reg <= '0;
            sm_index_reg <= '0;
            sm_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                udp_enable_reg <= cfg_write_data;
            end
            if (accept)
            begin
                fill_count_reg <= fill_count_next;
                sm_index_reg <= sm_index_next;
                sm_valid_reg <= sm_valid_next;
            end
        end
    end

    atrsm_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (rx_stream.valid),
        .push_ready (buf_ready),
        .push_data  (res),
        .result     (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |=> fill_count_reg == '0)
    else $error("fill count did not restart after a reported restart");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.frame_found |-> result.frame_end)
    else $error("start marker reported without a frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.frame_end |-> result.response_code == RESP_NONE)
    else $error("response code reported on a frame end");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !restart |=> fill_count_reg == $past(widx) + CNT_W'(1))
    else $error("fill count did not advance by one");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_LAST)
    else $error("fill count beyond buffer depth");
endmodule

`default_nettype wire
